@@ rtl/core/tgs_pkg.sv @@
// ----------------------------------------------------------------------------
// tgs_pkg: shared types, constants and arithmetic helpers
// Widths, item records and the divider and blend step functions used by the
// trilinear grid sampler.
// ----------------------------------------------------------------------------
package tgs_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int FRAC_BITS    = 12;
   localparam int COORD_BITS   = 8;
   localparam int GRID_ABITS   = 12;
   localparam int CELL_BITS    = 7;
   localparam int STRIDE_BITS  = 13;
   localparam int CSR_IDX_BITS = 2;

   // divider: (coord << FRAC_BITS) / cell_size, quotient = {cell, frac}
   localparam int DIV_BITS   = COORD_BITS + FRAC_BITS;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

   // address arithmetic
   localparam int SX_BITS   = 2 * STRIDE_BITS;
   localparam int MX_BITS   = COORD_BITS + SX_BITS;
   localparam int MY_BITS   = COORD_BITS + STRIDE_BITS;
   localparam int BASE_BITS = MX_BITS + 1;
   localparam int OFS_BITS  = SX_BITS + 1;
   localparam int WA_BITS   = BASE_BITS + 1;

   localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int OUT_DEPTH   = 16;
   localparam int OPTR_BITS   = $clog2(OUT_DEPTH);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CELL_SIZE     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_STRIDE    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLUMN_STRIDE = 2'd2;

   localparam logic [CELL_BITS-1:0]   CELL_SIZE_RESET     = 7'd8;
   localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RESET    = 13'd33;
   localparam logic [STRIDE_BITS-1:0] COLUMN_STRIDE_RESET = 13'd3;

   typedef struct packed {
      logic [CELL_BITS-1:0]   cell_size;
      logic [STRIDE_BITS-1:0] row_stride;
      logic [STRIDE_BITS-1:0] column_stride;
   } cfg_type;

   typedef struct packed {
      logic [CELL_BITS-1:0] rem;
      logic [DIV_BITS-1:0]  qd;
   } div_state_type;

   typedef struct packed {
      logic                   kind;
      logic [GRID_ABITS-1:0]  grid_address;
      logic [SAMPLE_BITS-1:0] grid_value;
      div_state_type [2:0]    lane;
   } front_stage_type;

   typedef struct packed {
      logic                             kind;
      logic [GRID_ABITS-1:0]            grid_address;
      logic [SAMPLE_BITS-1:0]           grid_value;
      logic [2:0][COORD_BITS-1:0]       cidx;
      logic [2:0][FRAC_BITS-1:0]        frac;
   } item_type;

   // four restoring division steps, quotient bits shift in at the bottom
   function automatic div_state_type div_steps(div_state_type s,
                                               logic [CELL_BITS-1:0] d);
      div_state_type      t;
      logic [CELL_BITS:0] r;
      t = s;
      for (int i = 0; i < DIV_STEPS; i++) begin
         r    = {t.rem, t.qd[DIV_BITS-1]};
         t.qd = {t.qd[DIV_BITS-2:0], 1'b0};
         if (r >= {1'b0, d}) begin
            t.rem   = CELL_BITS'(r - {1'b0, d});
            t.qd[0] = 1'b1;
         end else begin
            t.rem = r[CELL_BITS-1:0];
         end
      end
      return t;
   endfunction

   // (b - a) * f, signed
   function automatic logic signed [PROD_BITS-1:0] lerp_prod(
      logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b,
      logic [FRAC_BITS-1:0] f);
      logic signed [SAMPLE_BITS:0]  d;
      logic signed [FRAC_BITS:0]    fs;
      logic signed [PROD_BITS-1:0]  p;
      d  = $signed({b[SAMPLE_BITS-1], b}) - $signed({a[SAMPLE_BITS-1], a});
      fs = $signed({1'b0, f});
      p  = d * fs;
      return p;
   endfunction

   // a + (p >>> FRAC_BITS), kept to sample width (result stays in range)
   function automatic logic [SAMPLE_BITS-1:0] lerp_sum(
      logic [SAMPLE_BITS-1:0] a, logic [PROD_BITS-1:0] p);
      return a + p[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
   endfunction

endpackage

@@ rtl/core/trilinear_grid_sampler_core.sv @@
// ----------------------------------------------------------------------------
// trilinear_grid_sampler_core: trilinear sampler over a coarse 3D grid
// Stores Q2.14 grid samples and answers fine-grid point queries with the
// trilinear blend of the eight surrounding corner samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Request side is a queue: drive req_* and raise req_push; the beat is
//    taken on a clock edge with req_full low. req_kind 0 stores
//    req_grid_value at req_grid_address and gives no result; req_kind 1 is
//    a query at (req_coord_x, req_coord_y, req_coord_z).
//  - Result side is a queue: while rsp_empty is low the oldest result is on
//    rsp_sample_out / rsp_out_of_range; rsp_pop takes it.
//  - Configuration: csr_valid/csr_ready write channel, always ready. Write
//    only while the block is drained.
//  - Throughput: one beat per cycle while req_full is low. From accept to
//    result an item passes the coordinate divider, the decoupling queue,
//    then address, corner fetch and the three blend levels.
//  - Corner samples come from eight grid copies, each one write and one read
//    port, so all corners are read in the same cycle.
//  - A stalled result side fills the 16-entry result FIFO; queries then wait
//    at the head of the decoupling queue, that queue fills, the divider
//    stops and req_full rises. Nothing is dropped.
//  - Synchronous reset empties all queues and restores the registers
//    (cell size 8, strides 33 and 3). Grid contents are not cleared.
// ----------------------------------------------------------------------------
module trilinear_grid_sampler_core (
   input  logic                                clock,
   input  logic                                reset,
   // request beats
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_kind,
   input  logic [tgs_pkg::GRID_ABITS-1:0]      req_grid_address,
   input  logic signed [tgs_pkg::SAMPLE_BITS-1:0] req_grid_value,
   input  logic [tgs_pkg::COORD_BITS-1:0]      req_coord_x,
   input  logic [tgs_pkg::COORD_BITS-1:0]      req_coord_y,
   input  logic [tgs_pkg::COORD_BITS-1:0]      req_coord_z,
   // result beats
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [tgs_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                rsp_out_of_range,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tgs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tgs_pkg::STRIDE_BITS-1:0]     csr_wdata
);

   tgs_pkg::cfg_type  cfg_ff;
   tgs_pkg::item_type front_item, head_item;
   logic              front_valid, front_ready, queue_ready;
   logic              head_valid, head_pop;
   logic [2:0][tgs_pkg::COORD_BITS-1:0] coord;
   logic [tgs_pkg::SAMPLE_BITS-1:0]     sample;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_size     <= tgs_pkg::CELL_SIZE_RESET;
         cfg_ff.row_stride    <= tgs_pkg::ROW_STRIDE_RESET;
         cfg_ff.column_stride <= tgs_pkg::COLUMN_STRIDE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tgs_pkg::CSR_CELL_SIZE: begin
               cfg_ff.cell_size <= csr_wdata[tgs_pkg::CELL_BITS-1:0];
            end
            tgs_pkg::CSR_ROW_STRIDE: begin
               cfg_ff.row_stride <= csr_wdata;
            end
            tgs_pkg::CSR_COLUMN_STRIDE: begin
               cfg_ff.column_stride <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign coord    = {req_coord_z, req_coord_y, req_coord_x};
   assign req_full = !front_ready;

   // front: intake and divide
   tgs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (req_push),
      .in_ready        (front_ready),
      .in_kind         (req_kind),
      .in_grid_address (req_grid_address),
      .in_grid_value   (req_grid_value),
      .in_coord        (coord),
      .out_valid       (front_valid),
      .out_ready       (queue_ready),
      .out_item        (front_item)
   );

   // decoupling queue
   tgs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_item  (front_item),
      .push_ready (queue_ready),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // back: addresses, corner fetch, blends, result FIFO
   tgs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_sample (sample),
      .rsp_oor    (rsp_out_of_range)
   );

   assign rsp_sample_out = sample;

endmodule

@@ rtl/core/tgs_grid_bank.sv @@
// ----------------------------------------------------------------------------
// tgs_grid_bank: one copy of the coarse grid
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tgs_grid_bank #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule

@@ rtl/core/tgs_front.sv @@
// ----------------------------------------------------------------------------
// tgs_front: intake and coordinate divider
// Registers each beat and splits its coordinates into cell and fraction in a
// stallable pipeline, four quotient bits per stage.
// ----------------------------------------------------------------------------
module tgs_front (
   input  logic                               clock,
   input  logic                               reset,
   input  tgs_pkg::cfg_type                   cfg,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic                               in_kind,
   input  logic [tgs_pkg::GRID_ABITS-1:0]     in_grid_address,
   input  logic [tgs_pkg::SAMPLE_BITS-1:0]    in_grid_value,
   input  logic [2:0][tgs_pkg::COORD_BITS-1:0] in_coord,
   output logic                               out_valid,
   input  logic                               out_ready,
   output tgs_pkg::item_type                  out_item
);

   localparam int NS = tgs_pkg::DIV_STAGES + 1;

   logic [NS-1:0]             vld_ff, vld_in;
   tgs_pkg::front_stage_type  st_ff [NS];
   tgs_pkg::front_stage_type  st_in [NS];
   logic [tgs_pkg::CELL_BITS-1:0] divisor;
   logic                      adv;

   assign adv      = !vld_ff[NS-1] || out_ready;
   assign in_ready = adv;
   assign divisor  = (cfg.cell_size == '0) ? tgs_pkg::CELL_BITS'(1) : cfg.cell_size;

   always_comb begin
      st_in[0].kind         = in_kind;
      st_in[0].grid_address = in_grid_address;
      st_in[0].grid_value   = in_grid_value;
      for (int l = 0; l < 3; l++) begin
         st_in[0].lane[l].rem = '0;
         st_in[0].lane[l].qd  = {in_coord[l], {tgs_pkg::FRAC_BITS{1'b0}}};
      end
      vld_in[0] = in_valid;
      for (int k = 1; k < NS; k++) begin
         st_in[k] = st_ff[k-1];
         for (int l = 0; l < 3; l++) begin
            st_in[k].lane[l] = tgs_pkg::div_steps(st_ff[k-1].lane[l], divisor);
         end
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      out_valid             = vld_ff[NS-1];
      out_item.kind         = st_ff[NS-1].kind;
      out_item.grid_address = st_ff[NS-1].grid_address;
      out_item.grid_value   = st_ff[NS-1].grid_value;
      for (int l = 0; l < 3; l++) begin
         out_item.cidx[l] = st_ff[NS-1].lane[l].qd[tgs_pkg::DIV_BITS-1:tgs_pkg::FRAC_BITS];
         out_item.frac[l] = st_ff[NS-1].lane[l].qd[tgs_pkg::FRAC_BITS-1:0];
      end
   end

endmodule

@@ rtl/core/tgs_queue.sv @@
// ----------------------------------------------------------------------------
// tgs_queue: decoupling queue between front and back
// Small register FIFO of classified items.
// ----------------------------------------------------------------------------
module tgs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tgs_pkg::item_type push_item,
   output logic              push_ready,
   input  logic              pop,
   output logic              head_valid,
   output tgs_pkg::item_type head_item
);

   tgs_pkg::item_type              mem_ff [tgs_pkg::QUEUE_DEPTH];
   logic [tgs_pkg::QPTR_BITS-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [tgs_pkg::QPTR_BITS:0]    cnt_ff, cnt_in;
   logic                           do_push, do_pop;

   assign push_ready = cnt_ff != (tgs_pkg::QPTR_BITS+1)'(tgs_pkg::QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_item  = mem_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff + tgs_pkg::QPTR_BITS'(do_push);
      rd_in  = rd_ff + tgs_pkg::QPTR_BITS'(do_pop);
      cnt_in = cnt_ff + (tgs_pkg::QPTR_BITS+1)'(do_push)
                      - (tgs_pkg::QPTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/tgs_back.sv @@
// ----------------------------------------------------------------------------
// tgs_back: address generation, corner fetch, blend and result buffer
// Free-running pipeline; query issue is gated by credits for the result FIFO.
// ----------------------------------------------------------------------------
module tgs_back (
   input  logic                            clock,
   input  logic                            reset,
   input  tgs_pkg::cfg_type                cfg,
   input  logic                            head_valid,
   input  tgs_pkg::item_type               head_item,
   output logic                            head_pop,
   input  logic                            rsp_pop,
   output logic                            rsp_empty,
   output logic [tgs_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                            rsp_oor
);

   localparam int SB = tgs_pkg::SAMPLE_BITS;
   localparam int FB = tgs_pkg::FRAC_BITS;

   // stride products, rebuilt every cycle from the registers
   logic [tgs_pkg::SX_BITS-1:0]  sx_ff;
   logic [tgs_pkg::OFS_BITS-1:0] ofs_ff [8];

   // credits
   logic [tgs_pkg::OPTR_BITS:0] credit_ff, credit_in;
   logic                        issue, rsp_take;

   // stage 1..3: address
   logic                             vld1_ff, vld2_ff, vld3_ff;
   tgs_pkg::item_type                it1_ff, it2_ff, it3_ff;
   logic [tgs_pkg::MX_BITS-1:0]      mx_ff;
   logic [tgs_pkg::MY_BITS-1:0]      my_ff;
   logic [tgs_pkg::BASE_BITS-1:0]    base_ff;
   logic [tgs_pkg::WA_BITS-1:0]      addr [8];
   logic [7:0]                       oor_bits;
   logic                             bank_we;

   // stage 4: corner data
   logic                             vld4_ff, oor4_ff;
   logic [1:0][FB-1:0]               fyz4_ff;
   logic [FB-1:0]                    fx4_ff;
   logic [SB-1:0]                    corner [8];

   // stages 5..9: blends
   logic                             vld5_ff, vld6_ff, vld7_ff, vld8_ff, vld9_ff;
   logic                             oor5_ff, oor6_ff, oor7_ff, oor8_ff, oor9_ff;
   logic [1:0][FB-1:0]               fyz5_ff, fyz6_ff;
   logic [FB-1:0]                    fz7_ff, fz8_ff;
   logic [tgs_pkg::PROD_BITS-1:0]    p5_ff [4];
   logic [SB-1:0]                    a5_ff [4];
   logic [SB-1:0]                    c6_ff [4];
   logic [tgs_pkg::PROD_BITS-1:0]    p7_ff [2];
   logic [SB-1:0]                    a7_ff [2];
   logic [SB-1:0]                    c8_ff [2];
   logic [tgs_pkg::PROD_BITS-1:0]    p9_ff;
   logic [SB-1:0]                    a9_ff;

   // result FIFO
   logic [SB-1:0]                    osample_ff [tgs_pkg::OUT_DEPTH];
   logic                             ooor_ff [tgs_pkg::OUT_DEPTH];
   logic [tgs_pkg::OPTR_BITS-1:0]    owr_ff, owr_in, ord_ff, ord_in;
   logic [tgs_pkg::OPTR_BITS:0]      ocnt_ff, ocnt_in;
   logic [SB-1:0]                    result;

   always_ff @(posedge clock) begin
      sx_ff <= tgs_pkg::SX_BITS'(cfg.row_stride) * tgs_pkg::SX_BITS'(cfg.column_stride);
      for (int i = 0; i < 8; i++) begin
         ofs_ff[i] <= (i[0] ? tgs_pkg::OFS_BITS'(sx_ff) : '0)
                    + (i[1] ? tgs_pkg::OFS_BITS'(cfg.column_stride) : '0)
                    + (i[2] ? tgs_pkg::OFS_BITS'(1) : '0);
      end
   end

   // issue: writes always go, queries need a free result slot
   assign issue    = head_valid && ((head_item.kind == tgs_pkg::KIND_WRITE)
                     || (credit_ff < (tgs_pkg::OPTR_BITS+1)'(tgs_pkg::OUT_DEPTH)));
   assign head_pop = issue;
   assign rsp_take = rsp_pop && !rsp_empty;

   always_comb begin
      credit_in = credit_ff
                + (tgs_pkg::OPTR_BITS+1)'(issue && (head_item.kind == tgs_pkg::KIND_QUERY))
                - (tgs_pkg::OPTR_BITS+1)'(rsp_take);
   end

   // corner addresses and range check
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         addr[i]     = tgs_pkg::WA_BITS'(base_ff) + tgs_pkg::WA_BITS'(ofs_ff[i]);
         oor_bits[i] = |addr[i][tgs_pkg::WA_BITS-1:tgs_pkg::GRID_ABITS];
      end
      bank_we = vld3_ff && (it3_ff.kind == tgs_pkg::KIND_WRITE);
   end

   for (genvar g = 0; g < 8; g++) begin : g_bank
      tgs_grid_bank #(
         .ADDR_BITS (tgs_pkg::GRID_ABITS),
         .DATA_BITS (SB)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we),
         .wr_addr (it3_ff.grid_address),
         .wr_data (it3_ff.grid_value),
         .rd_addr (addr[g][tgs_pkg::GRID_ABITS-1:0]),
         .rd_data (corner[g])
      );
   end

   assign result = oor9_ff ? '0 : tgs_pkg::lerp_sum(a9_ff, p9_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         vld1_ff   <= 1'b0;
         vld2_ff   <= 1'b0;
         vld3_ff   <= 1'b0;
         vld4_ff   <= 1'b0;
         vld5_ff   <= 1'b0;
         vld6_ff   <= 1'b0;
         vld7_ff   <= 1'b0;
         vld8_ff   <= 1'b0;
         vld9_ff   <= 1'b0;
      end else begin
         credit_ff <= credit_in;
         vld1_ff   <= issue;
         vld2_ff   <= vld1_ff;
         vld3_ff   <= vld2_ff;
         vld4_ff   <= vld3_ff && (it3_ff.kind == tgs_pkg::KIND_QUERY);
         vld5_ff   <= vld4_ff;
         vld6_ff   <= vld5_ff;
         vld7_ff   <= vld6_ff;
         vld8_ff   <= vld7_ff;
         vld9_ff   <= vld8_ff;
      end
   end

   always_ff @(posedge clock) begin
      it1_ff  <= head_item;
      it2_ff  <= it1_ff;
      it3_ff  <= it2_ff;
      mx_ff   <= tgs_pkg::MX_BITS'(it1_ff.cidx[0]) * tgs_pkg::MX_BITS'(sx_ff);
      my_ff   <= tgs_pkg::MY_BITS'(it1_ff.cidx[1])
               * tgs_pkg::MY_BITS'(cfg.column_stride);
      base_ff <= tgs_pkg::BASE_BITS'(mx_ff) + tgs_pkg::BASE_BITS'(my_ff)
               + tgs_pkg::BASE_BITS'(it2_ff.cidx[2]);
      oor4_ff <= |oor_bits;
      fx4_ff  <= it3_ff.frac[0];
      fyz4_ff <= it3_ff.frac[2:1];
      // along x
      for (int j = 0; j < 4; j++) begin
         p5_ff[j] <= tgs_pkg::lerp_prod(corner[2*j], corner[2*j+1], fx4_ff);
         a5_ff[j] <= corner[2*j];
         c6_ff[j] <= tgs_pkg::lerp_sum(a5_ff[j], p5_ff[j]);
      end
      oor5_ff <= oor4_ff;
      oor6_ff <= oor5_ff;
      fyz5_ff <= fyz4_ff;
      fyz6_ff <= fyz5_ff;
      // along y
      for (int k = 0; k < 2; k++) begin
         p7_ff[k] <= tgs_pkg::lerp_prod(c6_ff[2*k], c6_ff[2*k+1], fyz6_ff[0]);
         a7_ff[k] <= c6_ff[2*k];
         c8_ff[k] <= tgs_pkg::lerp_sum(a7_ff[k], p7_ff[k]);
      end
      oor7_ff <= oor6_ff;
      oor8_ff <= oor7_ff;
      fz7_ff  <= fyz6_ff[1];
      fz8_ff  <= fz7_ff;
      // along z
      p9_ff   <= tgs_pkg::lerp_prod(c8_ff[0], c8_ff[1], fz8_ff);
      a9_ff   <= c8_ff[0];
      oor9_ff <= oor8_ff;
   end

   // result FIFO, sized to the credits
   always_comb begin
      owr_in  = owr_ff + tgs_pkg::OPTR_BITS'(vld9_ff);
      ord_in  = ord_ff + tgs_pkg::OPTR_BITS'(rsp_take);
      ocnt_in = ocnt_ff + (tgs_pkg::OPTR_BITS+1)'(vld9_ff)
                        - (tgs_pkg::OPTR_BITS+1)'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vld9_ff) begin
         osample_ff[owr_ff] <= result;
         ooor_ff[owr_ff]    <= oor9_ff;
      end
   end

   assign rsp_empty  = ocnt_ff == '0;
   assign rsp_sample = osample_ff[ord_ff];
   assign rsp_oor    = ooor_ff[ord_ff];

endmodule

@@ rtl/core/tgs_checker.sv @@
// ----------------------------------------------------------------------------
// tgs_checker: port-level checks for the trilinear grid sampler
// Watches the request and result queues; bound to the top level.
// ----------------------------------------------------------------------------
module tgs_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_push,
   input logic                                   req_full,
   input logic                                   req_kind,
   input logic                                   rsp_empty,
   input logic                                   rsp_pop,
   input logic signed [tgs_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                                   rsp_out_of_range
);

   // queries accepted and not yet popped
   logic [15:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff + 16'(req_push && !req_full && (req_kind == tgs_pkg::KIND_QUERY))
                        - 16'(rsp_pop && !rsp_empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_out_of_range) |-> (rsp_sample_out == '0))
      else $error("out-of-range result carries a nonzero sample");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (pend_ff != '0))
      else $error("result shown without a pending query");

endmodule

bind trilinear_grid_sampler_core tgs_checker u_tgs_checker (.*);
